// ===== rtl/core/discrete_regulatory_network_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the regulatory network step block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DISCRETE_REGULATORY_NETWORK_STEP_MACROS_SVH
`define DISCRETE_REGULATORY_NETWORK_STEP_MACROS_SVH

`ifndef SYNTHESIS
`define DRN_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");
`define DRN_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DRN_ASSERT(name, clk, rst_n, prop)
`define DRN_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/core/drn_pkg.sv =====
// ----------------------------------------------------------------------------
// Regulatory network step package
// Shared widths, defaults and request codes.
// ----------------------------------------------------------------------------
package drn_pkg;

  localparam int MaxGenesDflt  = 8;
  localparam int LevelBitsDflt = 3;

  localparam int ReqTypeW = 2;
  localparam int GeneW    = 3;
  localparam int ValueW   = 4;
  localparam int FrozenW  = 4;
  localparam int ActiveW  = 4;
  localparam int OutW     = 24;

  localparam logic [ActiveW-1:0] ActiveReset = 4'd8;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_ARC   = 2'd0,
    REQ_CEIL  = 2'd1,
    REQ_LEVEL = 2'd2,
    REQ_STEP  = 2'd3
  } req_type_e;

endpackage

// ===== rtl/core/drn_if.sv =====
// ----------------------------------------------------------------------------
// Regulatory network step channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface drn_req_if;
  import drn_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ReqTypeW-1:0]       req_type;
  logic [GeneW-1:0]          source_gene;
  logic [GeneW-1:0]          target_gene;
  logic signed [ValueW-1:0]  write_value;
  logic [FrozenW-1:0]        frozen_gene;

  modport source (output valid, req_type, source_gene, target_gene, write_value,
                  frozen_gene, input ready);
  modport sink (input valid, req_type, source_gene, target_gene, write_value,
                frozen_gene, output ready);
endinterface

interface drn_rsp_if;
  import drn_pkg::*;

  logic            valid;
  logic            ready;
  logic [OutW-1:0] new_levels;

  modport source (output valid, new_levels, input ready);
  modport sink (input valid, new_levels, output ready);
endinterface

// ===== rtl/core/drn_update.sv =====
// ----------------------------------------------------------------------------
// Regulatory network level update
// Computes the next level of every gene from the current levels.
// ----------------------------------------------------------------------------
module drn_update #(
  parameter int MAX_GENES  = drn_pkg::MaxGenesDflt,
  parameter int LEVEL_BITS = drn_pkg::LevelBitsDflt
) (
  input  logic [LEVEL_BITS-1:0]        levels_i   [MAX_GENES],
  input  logic [LEVEL_BITS-1:0]        ceilings_i [MAX_GENES],
  input  logic signed [drn_pkg::ValueW-1:0] thr_i [MAX_GENES][MAX_GENES],
  input  logic [MAX_GENES-1:0]         active_i,
  input  logic [MAX_GENES-1:0]         frozen_i,
  output logic [LEVEL_BITS-1:0]        next_o     [MAX_GENES]
);
  import drn_pkg::*;

  localparam int CmpW = 6;
  localparam int SumW = LEVEL_BITS + 2;

  always_comb begin
    logic                   up;
    logic                   down;
    logic                   res;
    logic signed [CmpW-1:0] thr_s;
    logic signed [CmpW-1:0] lvl_s;
    logic signed [SumW-1:0] sum;
    for (int i = 0; i < MAX_GENES; i++) begin
      up   = 1'b0;
      down = 1'b0;
      for (int s = 0; s < MAX_GENES; s++) begin
        thr_s = CmpW'(thr_i[s][i]);
        lvl_s = signed'(CmpW'(levels_i[s]));
        res   = ((thr_s > 0) && (lvl_s >= thr_s)) || ((thr_s < 0) && (lvl_s < -thr_s));
        if (active_i[s] && (thr_s != 0)) begin
          up   = up | res;
          down = down | !res;
        end
      end
      sum = signed'(SumW'(levels_i[i])) + signed'(SumW'(up)) - signed'(SumW'(down));
      if (!active_i[i] || frozen_i[i]) begin
        next_o[i] = levels_i[i];
      end else if (sum < 0) begin
        next_o[i] = '0;
      end else if (sum > signed'(SumW'(ceilings_i[i]))) begin
        next_o[i] = ceilings_i[i];
      end else begin
        next_o[i] = sum[LEVEL_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/discrete_regulatory_network_step.sv =====
// ----------------------------------------------------------------------------
// Discrete regulatory network step
// Holds arc thresholds, ceilings and levels; a step item updates all genes.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Contents
// req_i     in   valid/ready    req_type, source_gene, target_gene,
//                               write_value, frozen_gene
// rsp_o     out  valid/ready    new_levels (step items only)
// cfg       in   cfg_we_i       active_genes
//
// Items are taken while req_i.ready is high; a step result is registered in the output buffer.
// The update of all genes is one combinational pass from the level registers.
// A two-entry output buffer lets items keep flowing while a result waits;
// req_i.ready drops only when both entries are full.
// Reset clears all thresholds and levels and sets every ceiling to the top.
// ----------------------------------------------------------------------------
`include "discrete_regulatory_network_step_macros.svh"

module discrete_regulatory_network_step #(
  parameter int MAX_GENES  = drn_pkg::MaxGenesDflt,
  parameter int LEVEL_BITS = drn_pkg::LevelBitsDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [drn_pkg::ActiveW-1:0]  cfg_wdata_i,
  drn_req_if.sink                      req_i,
  drn_rsp_if.source                    rsp_o
);
  import drn_pkg::*;

  localparam int LevelMax = (1 << LEVEL_BITS) - 1;
  localparam int PackW    = MAX_GENES * LEVEL_BITS;
  localparam int FullW    = (PackW > OutW) ? PackW : OutW;

  logic [ActiveW-1:0]        active_q;
  logic signed [ValueW-1:0]  thr_q      [MAX_GENES][MAX_GENES];
  logic [LEVEL_BITS-1:0]     ceilings_q [MAX_GENES];
  logic [LEVEL_BITS-1:0]     levels_q   [MAX_GENES];
  logic [LEVEL_BITS-1:0]     next_lvl   [MAX_GENES];

  logic [MAX_GENES-1:0]      active_mask;
  logic [MAX_GENES-1:0]      frozen_mask;
  logic [LEVEL_BITS-1:0]     wr_level;
  logic [PackW-1:0]          packed_lvl;
  logic [FullW-1:0]          packed_ext;
  logic [OutW-1:0]           result;

  logic                      req_acc;
  logic                      is_step;
  logic                      push;
  logic                      pop;
  logic                      out_valid_q, out_valid_d;
  logic                      skid_valid_q, skid_valid_d;
  logic [OutW-1:0]           out_data_q, out_data_d;
  logic [OutW-1:0]           skid_data_q, skid_data_d;

  assign req_i.ready = !skid_valid_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign is_step     = (req_i.req_type == REQ_STEP);
  assign push        = req_acc && is_step;
  assign pop         = out_valid_q && rsp_o.ready;

  always_comb begin
    for (int i = 0; i < MAX_GENES; i++) begin
      active_mask[i] = (32'(active_q) > i);
      frozen_mask[i] = (32'(req_i.frozen_gene) == (i + 1));
      packed_lvl[i*LEVEL_BITS +: LEVEL_BITS] = next_lvl[i];
    end
  end

  assign packed_ext = FullW'(packed_lvl);
  assign result     = packed_ext[OutW-1:0];

  always_comb begin
    if (req_i.write_value < 0) begin
      wr_level = '0;
    end else if (int'(req_i.write_value) > LevelMax) begin
      wr_level = LEVEL_BITS'(LevelMax);
    end else begin
      wr_level = LEVEL_BITS'(req_i.write_value);
    end
  end

  drn_update #(
    .MAX_GENES  (MAX_GENES),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_update (
    .levels_i   (levels_q),
    .ceilings_i (ceilings_q),
    .thr_i      (thr_q),
    .active_i   (active_mask),
    .frozen_i   (frozen_mask),
    .next_o     (next_lvl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
      for (int s = 0; s < MAX_GENES; s++) begin
        ceilings_q[s] <= LEVEL_BITS'(LevelMax);
        levels_q[s]   <= '0;
        for (int t = 0; t < MAX_GENES; t++) begin
          thr_q[s][t] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (req_acc) begin
        unique case (req_type_e'(req_i.req_type))
          REQ_ARC: begin
            for (int s = 0; s < MAX_GENES; s++) begin
              for (int t = 0; t < MAX_GENES; t++) begin
                if ((32'(req_i.source_gene) == s) && (32'(req_i.target_gene) == t)) begin
                  thr_q[s][t] <= req_i.write_value;
                end
              end
            end
          end
          REQ_CEIL: begin
            for (int g = 0; g < MAX_GENES; g++) begin
              if (32'(req_i.target_gene) == g) begin
                ceilings_q[g] <= wr_level;
              end
            end
          end
          REQ_LEVEL: begin
            for (int g = 0; g < MAX_GENES; g++) begin
              if (32'(req_i.target_gene) == g) begin
                levels_q[g] <= wr_level;
              end
            end
          end
          REQ_STEP: begin
            for (int g = 0; g < MAX_GENES; g++) begin
              levels_q[g] <= next_lvl[g];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q) begin
      if (push && pop) begin
        out_data_d = result;
      end else if (push) begin
        skid_data_d  = result;
        skid_valid_d = 1'b1;
      end else if (pop) begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      out_data_d  = result;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.new_levels = out_data_q;

  `DRN_ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni, skid_valid_q && !out_valid_q)
  `DRN_ASSERT(a_step_to_empty_out, clk_i, rst_ni, (push && !out_valid_q) |=> (out_valid_q && (out_data_q == $past(result))))
  `DRN_ASSERT(a_write_keeps_out, clk_i, rst_ni, (req_acc && !is_step && !pop) |=> ($stable(out_valid_q) && $stable(skid_valid_q)))

endmodule

// ===== tb/drn_level_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level predictor and checker for the regulatory network step
// Watches both channels and the active gene register, keeps its own copy of
// thresholds, ceilings and levels, and compares each returned level word
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module drn_level_checker
  import drn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ActiveW-1:0] cfg_wdata_i,
  drn_req_if                 req_mon,
  drn_rsp_if                 rsp_mon,
  output int                 open_steps_o,
  output int                 fail_count_o
);

  localparam int Genes = MaxGenesDflt;
  localparam int LvlW = LevelBitsDflt;
  localparam logic [LvlW-1:0] LevelTop = '1;
  localparam int ReportLimit = 10;

  logic signed [ValueW-1:0] threshold_q [Genes][Genes];
  logic [LvlW-1:0] ceiling_q [Genes];
  logic [LvlW-1:0] level_q [Genes];
  logic [ActiveW-1:0] active_q;
  logic [OutW-1:0] levels_due_q [$];

  function automatic logic [LvlW-1:0] clip_level(input logic signed [ValueW-1:0] raw);
    if (raw < 0) return '0;
    if (int'(raw) > int'(LevelTop)) return LevelTop;
    return raw[LvlW-1:0];
  endfunction

  // All genes move together from the old levels, so the new values are
  // collected first and stored afterwards.
  function automatic logic [OutW-1:0] advance_levels(input logic [FrozenW-1:0] frozen);
    int n;
    int lvl;
    int thr;
    bit up;
    bit down;
    logic [LvlW-1:0] next_lvl [Genes];
    logic [OutW-1:0] word;
    n = (int'(active_q) > Genes) ? Genes : int'(active_q);
    word = '0;
    for (int i = 0; i < Genes; i++) begin
      next_lvl[i] = level_q[i];
      if (i < n && int'(frozen) != i + 1) begin
        up = 1'b0;
        down = 1'b0;
        for (int s = 0; s < n; s++) begin
          thr = threshold_q[s][i];
          if (thr != 0) begin
            if ((thr > 0 && int'(level_q[s]) >= thr) || (thr < 0 && int'(level_q[s]) < -thr)) begin
              up = 1'b1;
            end else begin
              down = 1'b1;
            end
          end
        end
        lvl = int'(level_q[i]) + (up ? 1 : 0) - (down ? 1 : 0);
        if (lvl < 0) lvl = 0;
        if (lvl > int'(ceiling_q[i])) lvl = int'(ceiling_q[i]);
        next_lvl[i] = lvl[LvlW-1:0];
      end
    end
    for (int i = 0; i < Genes; i++) begin
      level_q[i] = next_lvl[i];
      word[i*LvlW +: LvlW] = next_lvl[i];
    end
    return word;
  endfunction

  task automatic log_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= ReportLimit) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [OutW-1:0] want;
    if (!rst_ni) begin
      for (int s = 0; s < Genes; s++) begin
        for (int t = 0; t < Genes; t++) threshold_q[s][t] = '0;
        ceiling_q[s] = LevelTop;
        level_q[s] = '0;
      end
      active_q = ActiveReset;
      levels_due_q.delete();
      open_steps_o = 0;
      fail_count_o = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (levels_due_q.size() == 0) begin
          log_failure($sformatf("new_levels %06h returned with no step item outstanding",
                                rsp_mon.new_levels));
        end else begin
          want = levels_due_q.pop_front();
          if (rsp_mon.new_levels !== want) begin
            log_failure($sformatf("new_levels mismatch: expected %06h, got %06h",
                                  want, rsp_mon.new_levels));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.req_type)
          REQ_ARC: begin
            threshold_q[req_mon.source_gene][req_mon.target_gene] = req_mon.write_value;
          end
          REQ_CEIL: begin
            ceiling_q[req_mon.target_gene] = clip_level(req_mon.write_value);
          end
          REQ_LEVEL: begin
            level_q[req_mon.target_gene] = clip_level(req_mon.write_value);
          end
          REQ_STEP: begin
            levels_due_q.push_back(advance_levels(req_mon.frozen_gene));
          end
          default: begin
          end
        endcase
      end
      if (cfg_we_i) active_q = cfg_wdata_i;
      open_steps_o = levels_due_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench top for the regulatory network step
// Drives directed and random write and step items under several active gene
// counts with random stalls on both channels, and reports the verdict of the
// level checker.
// ----------------------------------------------------------------------------
module tb_top;
  import drn_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 60;
  localparam int PhaseItems = 115;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ActiveW-1:0] cfg_wdata;
  bit idle_on = 1'b1;
  bit hold_rsp = 1'b0;
  int open_steps;
  int fail_count;

  drn_req_if req_ch ();
  drn_rsp_if rsp_ch ();

  discrete_regulatory_network_step DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  drn_level_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .open_steps_o (open_steps),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : response_side
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(input req_type_e kind, input logic [GeneW-1:0] src,
                              input logic [GeneW-1:0] tgt,
                              input logic signed [ValueW-1:0] val,
                              input logic [FrozenW-1:0] frz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.source_gene <= src;
    req_ch.target_gene <= tgt;
    req_ch.write_value <= val;
    req_ch.frozen_gene <= frz;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    req_type_e kind;
    logic signed [ValueW-1:0] val;
    logic [FrozenW-1:0] frz;
    pick = $urandom_range(0, 99);
    if (pick < 35) kind = REQ_ARC;
    else if (pick < 45) kind = REQ_CEIL;
    else if (pick < 65) kind = REQ_LEVEL;
    else kind = REQ_STEP;
    val = ValueW'($urandom_range(0, 15));
    if (kind == REQ_CEIL && $urandom_range(0, 3) != 0) val = ValueW'($urandom_range(4, 7));
    pick = $urandom_range(0, 3);
    if (pick == 0) frz = '0;
    else if (pick == 1) frz = FrozenW'($urandom_range(0, 15));
    else frz = FrozenW'($urandom_range(1, 8));
    send_request(kind, GeneW'($urandom_range(0, 7)), GeneW'($urandom_range(0, 7)), val, frz);
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_steps != 0) @(posedge clk);
  endtask

  task automatic write_active_genes(input logic [ActiveW-1:0] count);
    wait_for_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ActiveW-1:0] phase_active [7];
    phase_active = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd4, 4'd6, 4'd8};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= ActiveReset;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_ARC;
    req_ch.source_gene <= '0;
    req_ch.target_gene <= '0;
    req_ch.write_value <= '0;
    req_ch.frozen_gene <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_CEIL, 3'd0, 3'd7, -4'sd8, 4'd0);
    send_request(REQ_CEIL, 3'd7, 3'd0, 4'sd7, 4'd0);
    send_request(REQ_LEVEL, 3'd0, 3'd0, 4'sd7, 4'd0);
    send_request(REQ_LEVEL, 3'd0, 3'd7, 4'sd5, 4'd0);
    send_request(REQ_LEVEL, 3'd0, 3'd1, -4'sd1, 4'd0);
    send_request(REQ_LEVEL, 3'd0, 3'd2, 4'sd3, 4'd0);
    send_request(REQ_ARC, 3'd0, 3'd1, 4'sd7, 4'd0);
    send_request(REQ_ARC, 3'd2, 3'd1, 4'sd4, 4'd0);
    send_request(REQ_ARC, 3'd1, 3'd2, -4'sd8, 4'd0);
    send_request(REQ_ARC, 3'd2, 3'd3, -4'sd3, 4'd0);
    send_request(REQ_ARC, 3'd7, 3'd4, 4'sd1, 4'd0);
    send_request(REQ_ARC, 3'd4, 3'd4, 4'sd2, 4'd0);
    send_request(REQ_STEP, 3'd0, 3'd0, 4'sd0, 4'd0);
    send_request(REQ_STEP, 3'd7, 3'd7, -4'sd1, 4'd1);
    send_request(REQ_ARC, 3'd7, 3'd4, 4'sd0, 4'd0);
    send_request(REQ_STEP, 3'd0, 3'd0, 4'sd0, 4'd8);
    send_request(REQ_STEP, 3'd0, 3'd0, 4'sd0, 4'd15);
    send_request(REQ_ARC, 3'd3, 3'd6, -4'sd1, 4'd0);
    send_request(REQ_STEP, 3'd0, 3'd0, 4'sd0, 4'd3);

    for (int p = 0; p < 7; p++) begin
      write_active_genes(phase_active[p]);
      idle_on = (p != 6);
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 3 && k == 40) begin
          idle_on = 1'b0;
          hold_rsp = 1'b1;
          repeat (12) send_request(REQ_STEP, '0, '0, '0, FrozenW'($urandom_range(0, 8)));
          idle_on = 1'b1;
        end
        if (p == 4 && k == 60) wait_for_results();
        send_random_item();
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
